// ----- sv/bts_pkg.sv -----
// Shared types, constants and helpers for the bilinear texture sampler.
// No dependencies; used by every other file of the block except bts_ram.
package bts_pkg;

  localparam int ADDR_W     = 16;
  localparam int TEXEL_W    = 24;
  localparam int COORD_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = 8;
  localparam int WT_W       = 8;
  localparam int SIZE_W     = 9;
  localparam int CHAN_OUT_W = 16;
  localparam int MAX_DIM    = 256;

  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LOADED = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SAMPLE,
    OP_ZERO
  } op_t;

  // Settings seen by the datapath (sizes already clamped to 1..MAX_DIM)
  typedef struct packed {
    logic              loaded;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } tex_cfg_t;

  // One classified command between front and back
  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [TEXEL_W-1:0] texel;
    logic [IDX_W-1:0]   x0;
    logic [WT_W-1:0]    wu;
    logic [IDX_W-1:0]   y0;
    logic [WT_W-1:0]    wv;
  } cmd_t;

  typedef struct packed {
    logic [CHAN_OUT_W-1:0] red;
    logic [CHAN_OUT_W-1:0] green;
    logic [CHAN_OUT_W-1:0] blue;
  } rgb_out_t;

  // Repeat wrap of a signed Q8.16 coordinate into [0, 1] (17 bits)
  function automatic logic [FRAC_W:0] wrap_coord(input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] mag;
    logic [FRAC_W:0]    r;
    mag = '0 - b;
    if (b[COORD_W-1]) begin
      r = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, mag[FRAC_W-1:0]};
    end else if (b <= COORD_W'(1 << FRAC_W)) begin
      r = b[FRAC_W:0];
    end else begin
      r = {1'b0, b[FRAC_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ----- sv/bts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bts_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bts_front.sv -----
// Front end: takes input beats, wraps and scales coordinates, classifies.
// Depends on bts_pkg.
module bts_front import bts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tex_cfg_t           cfg,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic [ADDR_W-1:0]  in_texel_addr,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  input  logic [COORD_W-1:0] in_coord_u,
  input  logic [COORD_W-1:0] in_coord_v,
  output logic               q_push,
  output cmd_t               q_cmd,
  input  logic               q_full
);

  logic            f_v_r;
  cmd_t            f_cmd_r;
  cmd_t            cmd_nxt;
  logic            accept;
  logic            advance;
  logic [FRAC_W:0] cu, cv;
  logic [IDX_W-1:0] wm1, hm1;
  logic [FRAC_W+IDX_W:0] tu, tv;

  assign in_full = f_v_r && q_full;
  assign accept  = in_push && !in_full;
  assign advance = !f_v_r || !q_full;
  assign q_push  = f_v_r && !q_full;
  assign q_cmd   = f_cmd_r;

  // Wrap and scale by size - 1
  assign cu  = wrap_coord(in_coord_u);
  assign cv  = wrap_coord(in_coord_v);
  assign wm1 = IDX_W'(cfg.width - SIZE_W'(1));
  assign hm1 = IDX_W'(cfg.height - SIZE_W'(1));
  assign tu  = (FRAC_W+IDX_W+1)'(cu) * (FRAC_W+IDX_W+1)'(wm1);
  assign tv  = (FRAC_W+IDX_W+1)'(cv) * (FRAC_W+IDX_W+1)'(hm1);

  // Classify the beat
  always_comb begin
    cmd_nxt.addr  = in_texel_addr;
    cmd_nxt.texel = {in_red_in, in_green_in, in_blue_in};
    cmd_nxt.x0    = tu[FRAC_W+IDX_W-1:FRAC_W];
    cmd_nxt.wu    = tu[FRAC_W-1:FRAC_W-WT_W];
    cmd_nxt.y0    = tv[FRAC_W+IDX_W-1:FRAC_W];
    cmd_nxt.wv    = tv[FRAC_W-1:FRAC_W-WT_W];
    if (!in_func) begin
      cmd_nxt.op = OP_WRITE;
    end else if (cfg.loaded) begin
      cmd_nxt.op = OP_SAMPLE;
    end else begin
      cmd_nxt.op = OP_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (advance) begin
      f_v_r <= accept;
    end
    if (advance && accept) begin
      f_cmd_r <= cmd_nxt;
    end
  end

endmodule

// ----- sv/bts_queue.sv -----
// Short command queue between front and back ends.
// Depends on bts_pkg.
module bts_queue import bts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
    end
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ----- sv/bts_back.sv -----
// Back end: address generation, four-way texel fetch, bilinear blend and
// the result queue. Depends on bts_pkg and bts_ram.
module bts_back import bts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tex_cfg_t  cfg,
  input  cmd_t      q_head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output rgb_out_t  out_data
);

  // Stage 1: fetch addresses
  logic              s1_v_r;
  op_t               s1_op_r;
  logic [ADDR_W-1:0] s1_a_r [4];
  logic [TEXEL_W-1:0] s1_texel_r;
  logic [WT_W-1:0]   s1_wu_r, s1_wv_r;
  // Stage 2: texels from RAM
  logic              s2_v_r;
  op_t               s2_op_r;
  logic [WT_W-1:0]   s2_wu_r, s2_wv_r;
  logic [TEXEL_W-1:0] tex [4];
  // Stage 3: row blends
  logic              s3_v_r;
  op_t               s3_op_r;
  logic [WT_W-1:0]   s3_wv_r;
  logic [15:0]       s3_r0_r [3];
  logic [15:0]       s3_r1_r [3];

  logic [IDX_W-1:0]  x1, y1;
  logic [ADDR_W:0]   row0, row1;
  logic [ADDR_W-1:0] a_nxt [4];
  logic [1:0]        inflight;
  logic [OQ_PTR_W:0] oq_cnt_r;
  logic [OQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  rgb_out_t          oq_mem_r [OQ_DEPTH];
  logic              oq_push, oq_pop, issue;
  rgb_out_t          res;
  logic [WT_W:0]     wu_inv, wv_inv;
  logic [15:0]       r0_nxt [3];
  logic [15:0]       r1_nxt [3];

  // Issue only while the result queue has room for everything in flight
  assign inflight = 2'(s1_v_r) + 2'(s2_v_r) + 2'(s3_v_r);
  assign issue = !q_empty &&
                 ((OQ_PTR_W+2)'(oq_cnt_r) + (OQ_PTR_W+2)'(inflight)
                  < (OQ_PTR_W+2)'(OQ_DEPTH));
  assign q_pop = issue;

  // Neighbor indexes with edge clamp, row-major addresses
  always_comb begin
    x1 = (({1'b0, q_head.x0} + SIZE_W'(1)) >= cfg.width) ? q_head.x0
                                                           : q_head.x0 + 1'b1;
    y1 = (({1'b0, q_head.y0} + SIZE_W'(1)) >= cfg.height) ? q_head.y0
                                                            : q_head.y0 + 1'b1;
    row0 = (ADDR_W+1)'(q_head.y0) * (ADDR_W+1)'(cfg.width);
    row1 = (ADDR_W+1)'(y1) * (ADDR_W+1)'(cfg.width);
    a_nxt[0] = row0[ADDR_W-1:0] + ADDR_W'(q_head.x0);
    a_nxt[1] = row0[ADDR_W-1:0] + ADDR_W'(x1);
    a_nxt[2] = row1[ADDR_W-1:0] + ADDR_W'(q_head.x0);
    a_nxt[3] = row1[ADDR_W-1:0] + ADDR_W'(x1);
    if (q_head.op == OP_WRITE) begin
      a_nxt[0] = q_head.addr;
    end
  end

  // Four copies of the store, one per neighbor; writes go to all
  for (genvar k = 0; k < 4; k++) begin : g_bank
    bts_ram #(.DATA_W(TEXEL_W), .ADDR_W(ADDR_W)) u_ram (
      .clk   (clk),
      .we    (s1_v_r && (s1_op_r == OP_WRITE)),
      .waddr (s1_a_r[0]),
      .wdata (s1_texel_r),
      .raddr (s1_a_r[k]),
      .rdata (tex[k])
    );
  end

  // Horizontal blend per channel
  assign wu_inv = (WT_W+1)'(1 << WT_W) - (WT_W+1)'(s2_wu_r);
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r0_nxt[c] = 16'(17'(tex[0][23-8*c -: 8]) * 17'(wu_inv) +
                      17'(tex[1][23-8*c -: 8]) * 17'(s2_wu_r));
      r1_nxt[c] = 16'(17'(tex[2][23-8*c -: 8]) * 17'(wu_inv) +
                      17'(tex[3][23-8*c -: 8]) * 17'(s2_wu_r));
    end
  end

  // Vertical blend, drop 8 fraction bits
  assign wv_inv = (WT_W+1)'(1 << WT_W) - (WT_W+1)'(s3_wv_r);
  always_comb begin
    logic [24:0] v [3];
    for (int c = 0; c < 3; c++) begin
      v[c] = 25'(s3_r0_r[c]) * 25'(wv_inv) + 25'(s3_r1_r[c]) * 25'(s3_wv_r);
    end
    if (s3_op_r == OP_SAMPLE) begin
      res.red   = v[0][23:8];
      res.green = v[1][23:8];
      res.blue  = v[2][23:8];
    end else begin
      res = '0;
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
    s1_op_r    <= q_head.op;
    s1_a_r     <= a_nxt;
    s1_texel_r <= q_head.texel;
    s1_wu_r    <= q_head.wu;
    s1_wv_r    <= q_head.wv;
    s2_op_r    <= s1_op_r;
    s2_wu_r    <= s1_wu_r;
    s2_wv_r    <= s1_wv_r;
    s3_op_r    <= s2_op_r;
    s3_wv_r    <= s2_wv_r;
    s3_r0_r    <= r0_nxt;
    s3_r1_r    <= r1_nxt;
  end

  // Result queue
  assign oq_push   = s3_v_r && (s3_op_r != OP_WRITE);
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_data  = oq_mem_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop)  oq_rd_r <= oq_rd_r + 1'b1;
      oq_cnt_r <= oq_cnt_r + (OQ_PTR_W+1)'(oq_push) - (OQ_PTR_W+1)'(oq_pop);
    end
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

`ifndef ASSERT_OFF
  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r < (OQ_PTR_W+1)'(OQ_DEPTH)) || oq_pop)
    else $error("result queue overflow");
  a_issue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> s1_v_r ##1 s2_v_r ##1 s3_v_r)
    else $error("issued command lost in pipeline");
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_op_r == OP_WRITE) |-> !oq_push)
    else $error("write produced a result");
  a_oq_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= (OQ_PTR_W+1)'(OQ_DEPTH))
    else $error("result count out of range");
`endif

endmodule

// ----- sv/bilinear_texture_sampler_top.sv -----
// Top level of the bilinear texture sampler: configuration registers,
// front end, command queue and back end. Depends on bts_pkg and submodules.
//
// Usage:
//   Input channel (in_push / in_full): a beat with in_func = 0 writes one RGB
//   texel at in_texel_addr (y*width+x); in_func = 1 requests a bilinear sample
//   at the wrapped Q8.16 coordinates in_coord_u / in_coord_v.
//   Result channel (out_empty / out_pop): one 8.8 RGB beat per sample, in
//   order; writes produce nothing. Unloaded texture gives zeros.
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 width,
//   1 height, 2 loaded flag. Write only while the block is idle.
// Timing:
//   One item per cycle sustained while the result side keeps popping. A sample
//   goes from its input beat through the front register into the queue, from the
//   queue to the address stage, then through the texel RAM read, the horizontal
//   blend and the vertical blend into the result queue.
//   The four texels come from four replicated texel RAMs, one read port each.
// Reset clears the pipelines and queues and sets width = height = 1 and
//   loaded = 0; texel RAM contents stay undefined until written.
// When the receiver stalls, the 8-entry result queue fills, issue stops, the
//   4-entry command queue fills and in_full rises; nothing is dropped.
module bilinear_texture_sampler_top import bts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_func,
  input  logic [ADDR_W-1:0]     in_texel_addr,
  input  logic [7:0]            in_red_in,
  input  logic [7:0]            in_green_in,
  input  logic [7:0]            in_blue_in,
  input  logic [COORD_W-1:0]    in_coord_u,
  input  logic [COORD_W-1:0]    in_coord_v,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [CHAN_OUT_W-1:0] out_red_out,
  output logic [CHAN_OUT_W-1:0] out_green_out,
  output logic [CHAN_OUT_W-1:0] out_blue_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  logic [SIZE_W-1:0] width_r, height_r;
  logic              loaded_r;
  tex_cfg_t          cfg;
  logic              q_push, q_full, q_pop, q_empty;
  cmd_t              q_cmd, q_head;
  rgb_out_t          out_data;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(1);
      height_r <= SIZE_W'(1);
      loaded_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_LOADED: loaded_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Clamp sizes to 1..MAX_DIM
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_W'(MAX_DIM)) r = SIZE_W'(MAX_DIM);
    else r = s;
    return r;
  endfunction

  assign cfg.loaded = loaded_r;
  assign cfg.width  = clamp_size(width_r);
  assign cfg.height = clamp_size(height_r);

  bts_front u_front (
    .clk, .rst_n, .cfg,
    .in_push, .in_full, .in_func, .in_texel_addr,
    .in_red_in, .in_green_in, .in_blue_in, .in_coord_u, .in_coord_v,
    .q_push, .q_cmd, .q_full
  );

  bts_queue u_queue (
    .clk, .rst_n,
    .push (q_push), .push_cmd (q_cmd), .full (q_full),
    .pop (q_pop), .head (q_head), .empty (q_empty)
  );

  bts_back u_back (
    .clk, .rst_n, .cfg,
    .q_head, .q_empty, .q_pop,
    .out_empty, .out_pop, .out_data
  );

  assign out_red_out   = out_data.red;
  assign out_green_out = out_data.green;
  assign out_blue_out  = out_data.blue;

endmodule

// ----- sim/tb_bilinear_texture_sampler_top.sv -----
// Self-checking testbench for bilinear_texture_sampler_top: texel writes,
// wrapped bilinear samples, and size/loaded register settings with random idling.
// Depends on bts_pkg and the RTL of the block.
module tb_bilinear_texture_sampler_top;
  import bts_pkg::*;

  localparam logic       FUNC_WRITE  = 1'b0;
  localparam logic       FUNC_SAMPLE = 1'b1;
  localparam logic [1:0] CFG_SPARE   = 2'd3;  // index past the register list
  localparam int         LIMIT       = 3000000;
  localparam int         SETTLE      = 12;

  // Texel store shadow, register copy and queue of expected result beats
  class texel_scoreboard;
    logic [TEXEL_W-1:0] texels [0:65535];
    logic [SIZE_W-1:0]  width_q;
    logic [SIZE_W-1:0]  height_q;
    logic               loaded_q;
    rgb_out_t           filtered_q[$];
    int                 errors;

    function new();
      width_q  = 1;
      height_q = 1;
      loaded_q = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [SIZE_W-1:0] d);
      case (idx)
        CFG_WIDTH:  width_q  = d;
        CFG_HEIGHT: height_q = d;
        CFG_LOADED: loaded_q = d[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_size(logic [SIZE_W-1:0] s);
      if (s == 0) return 1;
      if (s > MAX_DIM) return MAX_DIM;
      return s;
    endfunction

    // Repeat wrap into [0, 1.0] with 16 fraction bits
    function logic [16:0] fold_coord(logic [23:0] b);
      logic [23:0] mag;
      mag = 24'h0 - b;
      if (b[23]) return 17'h10000 - {1'b0, mag[15:0]};
      if (b <= 24'h010000) return b[16:0];
      return {1'b0, b[15:0]};
    endfunction

    function logic [TEXEL_W-1:0] texel_at(int unsigned x, int unsigned y, int unsigned w);
      return texels[(y * w + x) & 32'hFFFF];
    endfunction

    // Work out the result of one accepted beat (writes give none)
    function void note_item(logic f, logic [15:0] addr, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [23:0] u, logic [23:0] v);
      int unsigned w, h, tu, tv, x0, y0, x1, y1, wu, wv, k;
      logic [TEXEL_W-1:0] t00, t10, t01, t11;
      longint unsigned a, bb, c, d, row0, row1, sum;
      logic [15:0] ch [3];
      rgb_out_t res;
      if (f == FUNC_WRITE) begin
        texels[addr] = {r, g, b};
        return;
      end
      if (!loaded_q) begin
        res = '0;
        filtered_q.push_back(res);
        return;
      end
      w  = eff_size(width_q);
      h  = eff_size(height_q);
      tu = fold_coord(u) * (w - 1);
      tv = fold_coord(v) * (h - 1);
      x0 = tu >> 16;
      y0 = tv >> 16;
      wu = (tu & 32'hFFFF) >> 8;
      wv = (tv & 32'hFFFF) >> 8;
      x1 = (x0 + 1 >= w) ? x0 : x0 + 1;
      y1 = (y0 + 1 >= h) ? y0 : y0 + 1;
      t00 = texel_at(x0, y0, w);
      t10 = texel_at(x1, y0, w);
      t01 = texel_at(x0, y1, w);
      t11 = texel_at(x1, y1, w);
      for (k = 0; k < 3; k++) begin
        a    = (t00 >> (16 - 8 * k)) & 8'hFF;
        bb   = (t10 >> (16 - 8 * k)) & 8'hFF;
        c    = (t01 >> (16 - 8 * k)) & 8'hFF;
        d    = (t11 >> (16 - 8 * k)) & 8'hFF;
        row0 = a * (256 - wu) + bb * wu;
        row1 = c * (256 - wu) + d * wu;
        sum  = row0 * (256 - wv) + row1 * wv;
        ch[k] = 16'((sum >> 8) & 16'hFFFF);
      end
      res.red   = ch[0];
      res.green = ch[1];
      res.blue  = ch[2];
      filtered_q.push_back(res);
    endfunction

    function void check_beat(rgb_out_t got);
      rgb_out_t exp_rgb;
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      exp_rgb = filtered_q.pop_front();
      if (got.red !== exp_rgb.red) begin
        $display("%0t: red expected %h actual %h", $time, exp_rgb.red, got.red);
        errors++;
      end
      if (got.green !== exp_rgb.green) begin
        $display("%0t: green expected %h actual %h", $time, exp_rgb.green, got.green);
        errors++;
      end
      if (got.blue !== exp_rgb.blue) begin
        $display("%0t: blue expected %h actual %h", $time, exp_rgb.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_func;
  logic [ADDR_W-1:0]     in_texel_addr;
  logic [7:0]            in_red_in;
  logic [7:0]            in_green_in;
  logic [7:0]            in_blue_in;
  logic [COORD_W-1:0]    in_coord_u;
  logic [COORD_W-1:0]    in_coord_v;
  logic                  out_empty;
  logic                  out_pop;
  logic [CHAN_OUT_W-1:0] out_red_out;
  logic [CHAN_OUT_W-1:0] out_green_out;
  logic [CHAN_OUT_W-1:0] out_blue_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [SIZE_W-1:0]     cfg_data;

  texel_scoreboard sb = new();
  bit  tx_burst;
  bit  rx_burst;
  int  cycles;
  int  stall_left;
  int  items_sent;
  logic [23:0] edge_coords [9] = '{24'h000000, 24'h010000, 24'h010001, 24'h7FFFFF,
                                   24'h800000, 24'hFF0000, 24'hFFFFFF, 24'h008000,
                                   24'hFE8000};

  bilinear_texture_sampler_top DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_beat('{out_red_out, out_green_out, out_blue_out});
    if (stall_left > 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if (!rx_burst) begin
        if ($urandom_range(0, 39) == 0) stall_left = $urandom_range(20, 60);
        else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
      end
    end
  end

  function int pick_gap();
    int p;
    if (tx_burst) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // One input beat; returns at its acceptance edge, or after the random gap that follows
  task send(logic f, logic [15:0] addr, logic [7:0] r, logic [7:0] g, logic [7:0] b,
            logic [23:0] u, logic [23:0] v);
    int gap;
    in_func       <= f;
    in_texel_addr <= addr;
    in_red_in     <= r;
    in_green_in   <= g;
    in_blue_in    <= b;
    in_coord_u    <= u;
    in_coord_v    <= v;
    in_push       <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(f, addr, r, g, b, u, v);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_write(logic [15:0] addr);
    send(FUNC_WRITE, addr, 8'($urandom), 8'($urandom), 8'($urandom),
         24'($urandom), 24'($urandom));
  endtask

  task send_sample(logic [23:0] u, logic [23:0] v);
    send(FUNC_SAMPLE, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), u, v);
  endtask

  function logic [23:0] rand_coord();
    if ($urandom_range(0, 2) == 0) return 24'($urandom_range(0, 24'h010000));
    return 24'($urandom);
  endfunction

  task write_reg(logic [1:0] idx, logic [SIZE_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // Let every expected beat arrive, then let trailing writes settle
  task drain();
    in_push <= 1'b0;
    while (sb.filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Configure, fill the whole texture, then random traffic over it
  task run_phase(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic ld, int n);
    int unsigned area;
    int i;
    tx_burst = ($urandom_range(0, 4) == 0);
    rx_burst = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, SIZE_W'($urandom));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_LOADED, {8'h0, ld});
    area = sb.eff_size(w) * sb.eff_size(h);
    for (i = 0; i < area; i++) send_write(16'(i));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 65) send_sample(rand_coord(), rand_coord());
      else if ($urandom_range(0, 4) == 0) send_write(16'($urandom));
      else send_write(16'($urandom_range(0, area - 1)));
    end
    drain();
  endtask

  initial begin
    int i;
    rst_n = 0; in_push = 0; out_pop = 0; cfg_valid = 0; cfg_index = CFG_WIDTH;
    cfg_data = 0; in_func = FUNC_WRITE; in_texel_addr = 0; in_red_in = 0;
    in_green_in = 0; in_blue_in = 0; in_coord_u = 0; in_coord_v = 0;
    cycles = 0; stall_left = 0; items_sent = 0; tx_burst = 0; rx_burst = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unloaded texture gives zeros at any coordinate
    for (i = 0; i < 5; i++) send_sample(edge_coords[i], edge_coords[8 - i]);
    send(FUNC_WRITE, 16'hFFFF, 8'hFF, 8'h00, 8'hFF, 24'h0, 24'h0);
    drain();
    // Directed: 2x2 texture with extreme bytes, coordinates at wrap corners
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 2);
    write_reg(CFG_LOADED, 1);
    send(FUNC_WRITE, 0, 8'h00, 8'hFF, 8'h00, 24'h0, 24'h0);
    send(FUNC_WRITE, 1, 8'hFF, 8'h00, 8'hFF, 24'h0, 24'h0);
    send(FUNC_WRITE, 2, 8'hFF, 8'hFF, 8'hFF, 24'h0, 24'h0);
    send(FUNC_WRITE, 3, 8'h00, 8'h00, 8'h00, 24'h0, 24'h0);
    for (i = 0; i < 9; i++) send_sample(edge_coords[i], edge_coords[(i + 4) % 9]);
    drain();

    // Size extremes (zero and oversize registers clamp), then an unloaded 3x3 texture
    run_phase(0, 5, 1, 40);
    run_phase(511, 2, 1, 30);
    run_phase(256, 1, 1, 20);
    run_phase(1, 256, 1, 20);
    run_phase(3, 3, 0, 30);

    while (items_sent < 1250) begin
      run_phase(SIZE_W'($urandom_range(1, 9)), SIZE_W'($urandom_range(1, 9)),
                $urandom_range(0, 6) != 0, 60);
    end

    drain();
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
